### rtl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// shared types, character codes and token helpers for the token scanner
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int MAX_TEXT_DEFAULT = 15;
    localparam int TEXT_BYTES       = 15;
    localparam int TEXT_W           = 8 * TEXT_BYTES;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QUEUE_PTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_LVL_W      = $clog2(QUEUE_DEPTH + 1);

    // character codes
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_QUOTE   = 8'h27;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_QMARK   = 8'h3F;
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_Z    = 8'h7A;
    localparam logic [7:0] CH_BAR     = 8'h7C;
    localparam logic [7:0] CH_TILDE   = 8'h7E;

    typedef enum logic [3:0] {
        KIND_EOF    = 4'd0,
        KIND_LPAREN = 4'd1,
        KIND_RPAREN = 4'd2,
        KIND_LBRACK = 4'd3,
        KIND_RBRACK = 4'd4,
        KIND_BAR    = 4'd5,
        KIND_ATOM   = 4'd6,
        KIND_INT    = 4'd7,
        KIND_VAR    = 4'd8,
        KIND_DOT    = 4'd9,
        KIND_ERROR  = 4'd10
    } kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_NUM     = 3'd2,
        MODE_VAR     = 3'd3,
        MODE_WORD    = 3'd4,
        MODE_QUOTE   = 3'd5,
        MODE_GRAPH   = 3'd6,
        MODE_DOT     = 3'd7
    } mode_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [15:0] int_value;
        logic [3:0]         text_length;
        logic [63:0]        text_low;
        logic [55:0]        text_high;
    } token_t;

    typedef struct packed {
        token_t tok;
        logic   last;
    } result_t;

    // what the idle mode does with one character
    typedef struct packed {
        logic  tok_valid;
        kind_t kind;
        logic  one_char;    // single-character atom text
        mode_t mode;
        logic  start_text;  // text restarts with this character
        logic  clear_text;
        logic  load_num;
    } idle_t;

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return c >= CH_UP_A && c <= CH_UP_Z;
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return c >= CH_LO_A && c <= CH_LO_Z;
    endfunction

    function automatic logic is_word_char(input logic [7:0] c);
        return is_lower(c) || is_upper(c) || is_numeral(c) || c == CH_UNDER;
    endfunction

    function automatic logic is_graph(input logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
               c == CH_BSLASH || c == CH_CARET || c == CH_LT || c == CH_GT ||
               c == CH_EQ || c == CH_TILDE || c == CH_QMARK || c == CH_AT ||
               c == CH_HASH || c == CH_AMP || c == CH_COLON;
    endfunction

    function automatic idle_t idle_step(input logic [7:0] c);
        idle_t r;
        r = '{tok_valid: 1'b0, kind: KIND_EOF, one_char: 1'b0, mode: MODE_IDLE,
              start_text: 1'b0, clear_text: 1'b0, load_num: 1'b0};
        if (is_blank(c)) begin
            r.tok_valid = 1'b0;
        end
        else if (c == CH_NUL) begin
            r.tok_valid = 1'b1;
            r.kind      = KIND_EOF;
        end
        else if (c == CH_PERCENT) begin
            r.mode = MODE_COMMENT;
        end
        else if (c == CH_LPAREN) begin
            r.tok_valid = 1'b1;
            r.kind      = KIND_LPAREN;
        end
        else if (c == CH_RPAREN) begin
            r.tok_valid = 1'b1;
            r.kind      = KIND_RPAREN;
        end
        else if (c == CH_LBRACK) begin
            r.tok_valid = 1'b1;
            r.kind      = KIND_LBRACK;
        end
        else if (c == CH_RBRACK) begin
            r.tok_valid = 1'b1;
            r.kind      = KIND_RBRACK;
        end
        else if (c == CH_BAR) begin
            r.tok_valid = 1'b1;
            r.kind      = KIND_BAR;
        end
        else if (c == CH_COMMA || c == CH_BANG || c == CH_SEMI) begin
            r.tok_valid  = 1'b1;
            r.kind       = KIND_ATOM;
            r.one_char   = 1'b1;
            r.start_text = 1'b1;
        end
        else if (c == CH_DOT) begin
            r.mode = MODE_DOT;
        end
        else if (c == CH_QUOTE) begin
            r.mode       = MODE_QUOTE;
            r.clear_text = 1'b1;
        end
        else if (is_numeral(c)) begin
            r.mode     = MODE_NUM;
            r.load_num = 1'b1;
        end
        else if (is_upper(c) || c == CH_UNDER) begin
            r.mode       = MODE_VAR;
            r.start_text = 1'b1;
        end
        else if (is_lower(c)) begin
            r.mode       = MODE_WORD;
            r.start_text = 1'b1;
        end
        else if (is_graph(c)) begin
            r.mode       = MODE_GRAPH;
            r.start_text = 1'b1;
        end
        else begin
            r.tok_valid = 1'b1;
            r.kind      = KIND_ERROR;
        end
        return r;
    endfunction

    // token carrying the kept text; bytes at or past count read as zero
    function automatic token_t text_token(input kind_t kind,
                                          input logic [TEXT_W-1:0] store,
                                          input logic [3:0] count);
        token_t t;
        logic [TEXT_W-1:0] masked;
        masked = '0;
        for (int i = 0; i < TEXT_BYTES; i++) begin
            if (4'(i) < count) begin
                masked[8*i +: 8] = store[8*i +: 8];
            end
        end
        t.kind        = kind;
        t.int_value   = '0;
        t.text_length = count;
        t.text_low    = masked[63:0];
        t.text_high   = masked[TEXT_W-1:64];
        return t;
    endfunction

    // token with no text, or one character of text
    function automatic token_t plain_token(input kind_t kind, input logic one_char,
                                           input logic [7:0] c);
        token_t t;
        t.kind        = kind;
        t.int_value   = '0;
        t.text_length = one_char ? 4'd1 : 4'd0;
        t.text_low    = one_char ? {56'd0, c} : 64'd0;
        t.text_high   = '0;
        return t;
    endfunction

endpackage

### rtl/pts_out_queue.sv
// ----------------------------------------------------------------------------
// pts_out_queue
// small result queue, takes up to two results a cycle and hands out one
// ----------------------------------------------------------------------------
module pts_out_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_count,
    input  pts_pkg::result_t push_a,
    input  pts_pkg::result_t push_b,
    output logic             room_two,
    output logic             out_valid,
    input  logic             out_ready,
    output pts_pkg::result_t out_data
);

    pts_pkg::result_t mem [pts_pkg::QUEUE_DEPTH];

    logic [pts_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [pts_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [pts_pkg::QUEUE_LVL_W-1:0] level_reg, level_next;
    logic [pts_pkg::QUEUE_PTR_W-1:0] wr_ptr_b;
    logic                            pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = level_reg != '0;
    assign out_data  = mem[rd_ptr_reg];
    assign room_two  = level_reg <= pts_pkg::QUEUE_LVL_W'(pts_pkg::QUEUE_DEPTH - 2);
    assign wr_ptr_b  = wr_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + pts_pkg::QUEUE_PTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + pts_pkg::QUEUE_PTR_W'(pop);
        level_next  = level_reg + pts_pkg::QUEUE_LVL_W'(push_count)
                      - pts_pkg::QUEUE_LVL_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push_a;
        end
        if (push_count == 2'd2)
        begin
            mem[wr_ptr_b] <= push_b;
        end
    end

endmodule

### rtl/prolog_token_scanner.sv
// ----------------------------------------------------------------------------
// prolog_token_scanner
// character-at-a-time tokenizer for prolog source text
// ----------------------------------------------------------------------------
// One source character enters per transaction on the slave side (zero marks
// end of buffer) and each character is decoded in the same cycle it is
// accepted: a class decode plus a small scan-mode update. A character can
// complete up to two tokens (the token it ends, then whatever it starts
// alone), and both go into a four-entry result queue; the master side hands
// out one token per cycle from the queue while the sink is ready. Input is
// taken every cycle as long as the queue has room for two tokens, so a
// stream where every character yields two tokens is held back by the single
// output port. Atom and variable text keeps at most MAX_TEXT characters; a
// graphic run that is full is closed and a new run starts. Integers wrap in
// 16 bits. A lone dot is held until the next character decides whether it
// ends the clause.
// ----------------------------------------------------------------------------
module prolog_token_scanner
#(
    parameter int MAX_TEXT = pts_pkg::MAX_TEXT_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] char_code
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [143:0] m_axis_tdata,   // [15:0] int_value, [19:16] text_length,
                                         // [83:20] text_low, [139:84] text_high,
                                         // [143:140] zero
    output logic [3:0]   m_axis_tuser,   // [3:0] token_kind
    output logic         m_axis_tlast    // last_of_input
);

    localparam int TW = pts_pkg::TEXT_W;

    // scanner state
    pts_pkg::mode_t   mode_reg, mode_next;
    logic [TW-1:0]    store_reg, store_next;
    logic [3:0]       count_reg, count_next;
    logic [15:0]      accum_reg, accum_next;

    logic             in_fire;
    logic [7:0]       c;
    pts_pkg::idle_t   idle;
    logic             run_idle;
    logic             t0_valid;
    pts_pkg::token_t  t0;
    logic             t1_valid;
    pts_pkg::token_t  t1;
    logic             app_en;
    logic [3:0]       app_idx;
    logic             dot_to_graph;
    logic [TW-1:0]    eff_store;
    logic [3:0]       eff_count;
    logic [15:0]      digit_val;

    // queue side
    logic [1:0]       push_count;
    pts_pkg::result_t push_a;
    pts_pkg::result_t push_b;
    logic             room_two;
    pts_pkg::result_t out_data;

    assign c             = s_axis_tdata;
    assign s_axis_tready = room_two;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign idle          = pts_pkg::idle_step(c);
    assign digit_val     = {12'd0, 4'(c - pts_pkg::CH_ZERO)};

    // a held dot followed by anything but a blank or end of buffer
    // becomes the first character of a graphic run
    assign dot_to_graph = mode_reg == pts_pkg::MODE_DOT && c != pts_pkg::CH_NUL
                          && !pts_pkg::is_blank(c);
    assign eff_store    = dot_to_graph ? {store_reg[TW-1:8], pts_pkg::CH_DOT} : store_reg;
    assign eff_count    = dot_to_graph ? 4'd1 : count_reg;

    always_comb
    begin
        mode_next  = mode_reg;
        store_next = store_reg;
        count_next = count_reg;
        accum_next = accum_reg;
        run_idle   = 1'b0;
        t0_valid   = 1'b0;
        t0         = pts_pkg::plain_token(pts_pkg::KIND_EOF, 1'b0, c);
        app_en     = 1'b0;
        app_idx    = count_reg;

        unique case (mode_reg)
            pts_pkg::MODE_IDLE:
            begin
                run_idle = 1'b1;
            end
            pts_pkg::MODE_COMMENT:
            begin
                if (c == pts_pkg::CH_NUL)
                begin
                    run_idle = 1'b1;
                end
                else if (c == pts_pkg::CH_LF)
                begin
                    mode_next = pts_pkg::MODE_IDLE;
                end
            end
            pts_pkg::MODE_NUM:
            begin
                if (pts_pkg::is_numeral(c))
                begin
                    // times ten as two shifts
                    accum_next = (accum_reg << 3) + (accum_reg << 1) + digit_val;
                end
                else
                begin
                    t0_valid     = 1'b1;
                    t0           = pts_pkg::plain_token(pts_pkg::KIND_INT, 1'b0, c);
                    t0.int_value = accum_reg;
                    run_idle     = 1'b1;
                end
            end
            pts_pkg::MODE_VAR, pts_pkg::MODE_WORD:
            begin
                if (pts_pkg::is_word_char(c))
                begin
                    app_en = 1'b1;
                end
                else
                begin
                    t0_valid = 1'b1;
                    t0       = pts_pkg::text_token(
                                   mode_reg == pts_pkg::MODE_VAR ? pts_pkg::KIND_VAR
                                                                 : pts_pkg::KIND_ATOM,
                                   store_reg, count_reg);
                    run_idle = 1'b1;
                end
            end
            pts_pkg::MODE_QUOTE:
            begin
                if (c == pts_pkg::CH_QUOTE)
                begin
                    t0_valid  = 1'b1;
                    t0        = pts_pkg::text_token(pts_pkg::KIND_ATOM, store_reg, count_reg);
                    mode_next = pts_pkg::MODE_IDLE;
                end
                else if (c == pts_pkg::CH_NUL)
                begin
                    // unterminated quote: atom, then eof
                    t0_valid = 1'b1;
                    t0       = pts_pkg::text_token(pts_pkg::KIND_ATOM, store_reg, count_reg);
                    run_idle = 1'b1;
                end
                else
                begin
                    app_en = 1'b1;
                end
            end
            pts_pkg::MODE_GRAPH, pts_pkg::MODE_DOT:
            begin
                if (mode_reg == pts_pkg::MODE_DOT && !dot_to_graph)
                begin
                    // clause-ending dot
                    t0_valid = 1'b1;
                    t0       = pts_pkg::plain_token(pts_pkg::KIND_DOT, 1'b0, c);
                    run_idle = 1'b1;
                end
                else
                begin
                    mode_next  = pts_pkg::MODE_GRAPH;
                    store_next = eff_store;
                    count_next = eff_count;
                    if (pts_pkg::is_graph(c))
                    begin
                        app_en  = 1'b1;
                        app_idx = eff_count;
                        if (eff_count >= 4'(MAX_TEXT))
                        begin
                            // full run goes out, this character opens a new one
                            t0_valid = 1'b1;
                            t0       = pts_pkg::text_token(pts_pkg::KIND_ATOM,
                                                           eff_store, eff_count);
                            app_idx  = 4'd0;
                        end
                    end
                    else
                    begin
                        t0_valid = 1'b1;
                        t0       = pts_pkg::text_token(pts_pkg::KIND_ATOM,
                                                       eff_store, eff_count);
                        run_idle = 1'b1;
                    end
                end
            end
            default:
            begin
                run_idle = 1'b1;
            end
        endcase

        // the character is rescanned from idle
        if (run_idle)
        begin
            mode_next = idle.mode;
            if (idle.start_text)
            begin
                app_en  = 1'b1;
                app_idx = 4'd0;
            end
            if (idle.clear_text)
            begin
                count_next = 4'd0;
            end
            if (idle.load_num)
            begin
                accum_next = digit_val;
            end
        end

        // append, dropped once the text is full
        if (app_en)
        begin
            if (app_idx < 4'(MAX_TEXT))
            begin
                count_next = app_idx + 4'd1;
                for (int i = 0; i < pts_pkg::TEXT_BYTES; i++)
                begin
                    if (app_idx == 4'(i))
                    begin
                        store_next[8*i +: 8] = c;
                    end
                end
            end
            else
            begin
                count_next = app_idx;
            end
        end
    end

    assign t1_valid = run_idle && idle.tok_valid;
    assign t1       = pts_pkg::plain_token(idle.kind, idle.one_char, c);

    // pack the step's results, last flag on the final one
    always_comb
    begin
        push_count  = in_fire ? (2'(t0_valid) + 2'(t1_valid)) : 2'd0;
        push_a.tok  = t0_valid ? t0 : t1;
        push_a.last = !(t0_valid && t1_valid);
        push_b.tok  = t1;
        push_b.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= pts_pkg::MODE_IDLE;
            count_reg <= '0;
            accum_reg <= '0;
        end
        else if (in_fire)
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            accum_reg <= accum_next;
        end
    end

    // text bytes are only read below the count, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            store_reg <= store_next;
        end
    end

    pts_out_queue u_out_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push_a     (push_a),
        .push_b     (push_b),
        .room_two   (room_two),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (out_data)
    );

    assign m_axis_tuser = out_data.tok.kind;
    assign m_axis_tlast = out_data.last;
    assign m_axis_tdata = {4'd0,
                           out_data.tok.text_high,
                           out_data.tok.text_low,
                           out_data.tok.text_length,
                           out_data.tok.int_value};

endmodule

### tb/prolog_token_scanner_checker.sv
// ----------------------------------------------------------------------------
// prolog_token_scanner_checker
// watches both stream channels, predicts the token stream and compares
// ----------------------------------------------------------------------------
// every character accepted on the slave side runs through a scan-mode model
// that yields the tokens it completes; every token accepted on the master
// side is compared field by field with the oldest prediction
// ----------------------------------------------------------------------------
module prolog_token_scanner_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,    // [7:0] char_code
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [143:0] m_axis_tdata,    // [15:0] int_value, [19:16] text_length,
                                          // [83:20] text_low, [139:84] text_high,
                                          // [143:140] zero
    input  logic [3:0]   m_axis_tuser,    // [3:0] token_kind
    input  logic         m_axis_tlast,
    output int           tokens_pending,
    output int           mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import pts_pkg::*;

    localparam int TEXT_CAP = pts_pkg::MAX_TEXT_DEFAULT;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] value;
        logic [3:0]  text_len;
        logic [63:0] low_text;
        logic [55:0] high_text;
        logic        last;
    } scan_token_t;

    // scanner state
    mode_t       cur_mode;
    logic [7:0]  text_chars [TEXT_CAP];
    int          text_used;
    logic [15:0] num_value;

    scan_token_t step_tokens [$];
    scan_token_t tokens_due [$];
    int          fault_total;
    int          token_index;

    function automatic bit blank_code(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

    function automatic bit digit_code(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit upper_code(input logic [7:0] c);
        return c >= CH_UP_A && c <= CH_UP_Z;
    endfunction

    function automatic bit lower_code(input logic [7:0] c);
        return c >= CH_LO_A && c <= CH_LO_Z;
    endfunction

    function automatic bit name_code(input logic [7:0] c);
        return lower_code(c) || upper_code(c) || digit_code(c) || c == CH_UNDER;
    endfunction

    function automatic bit symbol_code(input logic [7:0] c);
        case (c)
            CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_BSLASH, CH_CARET, CH_LT,
            CH_GT, CH_EQ, CH_TILDE, CH_QMARK, CH_AT, CH_HASH, CH_AMP, CH_COLON:
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic push_token(input kind_t k);
        scan_token_t t;
        t = '0;
        t.kind = k;
        if (k == KIND_INT)
            t.value = num_value;
        if (k == KIND_ATOM || k == KIND_VAR)
        begin
            t.text_len = 4'(text_used);
            for (int i = 0; i < text_used; i++)
            begin
                if (i < 8)
                    t.low_text[8*i +: 8] = text_chars[i];
                else
                    t.high_text[8*(i-8) +: 8] = text_chars[i];
            end
        end
        if (step_tokens.size() < 2)
            step_tokens.push_back(t);
    endtask

    // characters past the cap are dropped
    task automatic add_char(input logic [7:0] c);
        if (text_used < TEXT_CAP)
        begin
            text_chars[text_used] = c;
            text_used++;
        end
    endtask

    task automatic open_text(input mode_t m, input logic [7:0] c);
        cur_mode  = m;
        text_used = 0;
        add_char(c);
    endtask

    task automatic from_idle(input logic [7:0] c);
        cur_mode = MODE_IDLE;
        if (!blank_code(c))
        begin
            if (c == CH_NUL)
                push_token(KIND_EOF);
            else if (c == CH_PERCENT)
                cur_mode = MODE_COMMENT;
            else if (c == CH_LPAREN)
                push_token(KIND_LPAREN);
            else if (c == CH_RPAREN)
                push_token(KIND_RPAREN);
            else if (c == CH_LBRACK)
                push_token(KIND_LBRACK);
            else if (c == CH_RBRACK)
                push_token(KIND_RBRACK);
            else if (c == CH_BAR)
                push_token(KIND_BAR);
            else if (c == CH_COMMA || c == CH_BANG || c == CH_SEMI)
            begin
                text_used = 0;
                add_char(c);
                push_token(KIND_ATOM);
            end
            else if (c == CH_DOT)
                cur_mode = MODE_DOT;
            else if (c == CH_QUOTE)
            begin
                cur_mode  = MODE_QUOTE;
                text_used = 0;
            end
            else if (digit_code(c))
            begin
                cur_mode  = MODE_NUM;
                num_value = 16'(c - CH_ZERO);
            end
            else if (upper_code(c) || c == CH_UNDER)
                open_text(MODE_VAR, c);
            else if (lower_code(c))
                open_text(MODE_WORD, c);
            else if (symbol_code(c))
                open_text(MODE_GRAPH, c);
            else
                push_token(KIND_ERROR);
        end
    endtask

    // a full graphic run is closed and the character starts a new one
    task automatic symbol_run(input logic [7:0] c);
        if (symbol_code(c))
        begin
            if (text_used >= TEXT_CAP)
            begin
                push_token(KIND_ATOM);
                text_used = 0;
            end
            add_char(c);
        end
        else
        begin
            push_token(KIND_ATOM);
            from_idle(c);
        end
    endtask

    task automatic scan_char(input logic [7:0] c);
        scan_token_t t;
        step_tokens = {};
        case (cur_mode)
            MODE_COMMENT:
                if (c == CH_NUL)
                    from_idle(c);
                else if (c == CH_LF)
                    cur_mode = MODE_IDLE;
            MODE_NUM:
                if (digit_code(c))
                    num_value = num_value * 16'd10 + 16'(c - CH_ZERO);
                else
                begin
                    push_token(KIND_INT);
                    from_idle(c);
                end
            MODE_VAR, MODE_WORD:
                if (name_code(c))
                    add_char(c);
                else
                begin
                    push_token(cur_mode == MODE_VAR ? KIND_VAR : KIND_ATOM);
                    from_idle(c);
                end
            MODE_QUOTE:
                if (c == CH_QUOTE)
                begin
                    push_token(KIND_ATOM);
                    cur_mode = MODE_IDLE;
                end
                else if (c == CH_NUL)
                begin
                    push_token(KIND_ATOM);
                    from_idle(c);
                end
                else
                    add_char(c);
            MODE_GRAPH:
                symbol_run(c);
            MODE_DOT:
                if (c == CH_NUL || blank_code(c))
                begin
                    push_token(KIND_DOT);
                    from_idle(c);
                end
                else
                begin
                    open_text(MODE_GRAPH, CH_DOT);
                    symbol_run(c);
                end
            default:
                from_idle(c);
        endcase
        if (step_tokens.size() > 0)
        begin
            t = step_tokens.pop_back();
            t.last = 1'b1;
            step_tokens.push_back(t);
        end
        while (step_tokens.size() > 0)
            tokens_due.push_back(step_tokens.pop_front());
    endtask

    task automatic log_fault(input string what, input scan_token_t want);
        if (fault_total < 10)
        begin
            $display("token %0d %s: expected kind %0d int %0d len %0d text %h_%h last %b",
                     token_index, what, want.kind, $signed(want.value), want.text_len,
                     want.high_text, want.low_text, want.last);
            $display("    got kind %0d int %0d len %0d text %h_%h pad %h last %b",
                     m_axis_tuser, $signed(m_axis_tdata[15:0]), m_axis_tdata[19:16],
                     m_axis_tdata[139:84], m_axis_tdata[83:20], m_axis_tdata[143:140],
                     m_axis_tlast);
        end
        fault_total++;
    endtask

    task automatic check_token();
        scan_token_t want;
        if (tokens_due.size() == 0)
        begin
            want = '0;
            log_fault("with none expected", want);
        end
        else
        begin
            want = tokens_due.pop_front();
            if (m_axis_tuser !== want.kind ||
                m_axis_tdata[15:0] !== want.value ||
                m_axis_tdata[19:16] !== want.text_len ||
                m_axis_tdata[83:20] !== want.low_text ||
                m_axis_tdata[139:84] !== want.high_text ||
                m_axis_tdata[143:140] !== 4'd0 ||
                m_axis_tlast !== want.last)
                log_fault("mismatch", want);
        end
        token_index++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_mode    = MODE_IDLE;
            text_used   = 0;
            num_value   = '0;
            tokens_due  = {};
            fault_total = 0;
            token_index = 0;
            tokens_pending <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                scan_char(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                check_token();
            tokens_pending <= tokens_due.size();
            mismatch_count <= fault_total;
        end
    end

endmodule

### tb/prolog_token_scanner_tb.sv
// ----------------------------------------------------------------------------
// prolog_token_scanner_tb
// stimulus and verdict for the prolog token scanner
// ----------------------------------------------------------------------------
// a short directed clause touches every token kind and the dot, quote, comment
// and unknown-character cases; random fragments of well-formed source
// (names, numbers, quoted text, graphic runs, punctuation, comments, end of
// buffer) mixed with raw noise follow. both sides idle at random apart from
// one calm stretch. the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module prolog_token_scanner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pts_pkg::*;

    localparam int CHAR_GOAL   = 1050;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 20;

    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata  = 8'd0;    // [7:0] char_code
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [143:0] m_axis_tdata;            // [15:0] int_value, [19:16] text_length,
                                           // [83:20] text_low, [139:84] text_high,
                                           // [143:140] zero
    logic [3:0]   m_axis_tuser;            // [3:0] token_kind
    logic         m_axis_tlast;

    int tokens_pending;
    int mismatch_count;
    int chars_sent  = 0;
    int cycle_count = 0;
    bit calm        = 1'b0;                // no idling on either side while set

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    prolog_token_scanner i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    prolog_token_scanner_checker i_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .tokens_pending (tokens_pending),
        .mismatch_count (mismatch_count)
    );

    // token sink stalls about a quarter of the cycles
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 25);
    end

    // one character transaction; valid stays high into the next one unless
    // a gap is drawn, so it is never lowered and raised in the same step
    task automatic send_char(input logic [7:0] c, input bit tally);
        if (!calm && $urandom_range(0, 99) < 25)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < 25);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (tally)
            chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], 1'b1);
    endtask

    // stop sending until every predicted token has come out
    task automatic hold_off();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (tokens_pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] name_pick();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(CH_LO_A, CH_LO_Z));
            1:       return 8'($urandom_range(CH_UP_A, CH_UP_Z));
            2:       return 8'($urandom_range(CH_ZERO, CH_NINE));
            default: return CH_UNDER;
        endcase
    endfunction

    function automatic logic [7:0] symbol_pick();
        case ($urandom_range(0, 14))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            3:       return CH_SLASH;
            4:       return CH_BSLASH;
            5:       return CH_CARET;
            6:       return CH_LT;
            7:       return CH_GT;
            8:       return CH_EQ;
            9:       return CH_TILDE;
            10:      return CH_QMARK;
            11:      return CH_AT;
            12:      return CH_HASH;
            13:      return CH_AMP;
            default: return CH_COLON;
        endcase
    endfunction

    function automatic logic [7:0] punct_pick();
        case ($urandom_range(0, 7))
            0:       return CH_LPAREN;
            1:       return CH_RPAREN;
            2:       return CH_LBRACK;
            3:       return CH_RBRACK;
            4:       return CH_BAR;
            5:       return CH_COMMA;
            6:       return CH_BANG;
            default: return CH_SEMI;
        endcase
    endfunction

    function automatic logic [7:0] blank_pick();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // one random source fragment; mostly short, now and then past the
    // text cap so long names, quotes, numbers and graphic runs show up
    task automatic send_piece();
        int         pick;
        int         span;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        span = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 20) : $urandom_range(0, 5);
        if (pick < 12)
        begin
            // variable, uppercase or underscore start
            if ($urandom_range(0, 4) == 0)
                send_char(CH_UNDER, 1'b1);
            else
                send_char(8'($urandom_range(CH_UP_A, CH_UP_Z)), 1'b1);
            repeat (span) send_char(name_pick(), 1'b1);
        end
        else if (pick < 26)
        begin
            // lowercase word atom
            send_char(8'($urandom_range(CH_LO_A, CH_LO_Z)), 1'b1);
            repeat (span) send_char(name_pick(), 1'b1);
        end
        else if (pick < 36)
        begin
            // integer, long runs wrap past 16 bits
            repeat (span + 1) send_char(8'($urandom_range(CH_ZERO, CH_NINE)), 1'b1);
        end
        else if (pick < 44)
        begin
            // quoted text with any non-quote, non-zero code, high codes included;
            // now and then left open for end of buffer to close it
            send_char(CH_QUOTE, 1'b1);
            repeat (span)
            begin
                do
                    c = 8'($urandom_range(1, 255));
                while (c == CH_QUOTE);
                send_char(c, 1'b1);
            end
            send_char(($urandom_range(0, 9) == 0) ? CH_NUL : CH_QUOTE, 1'b1);
        end
        else if (pick < 52)
        begin
            // graphic run, full runs split
            repeat (span + 1) send_char(symbol_pick(), 1'b1);
        end
        else if (pick < 66)
            send_char(punct_pick(), 1'b1);
        else if (pick < 76)
            send_char(blank_pick(), 1'b1);
        else if (pick < 80)
        begin
            // clause end
            send_char(CH_DOT, 1'b1);
            send_char(($urandom_range(0, 3) == 0) ? CH_NUL : blank_pick(), 1'b1);
        end
        else if (pick < 83)
        begin
            // dot followed by anything at all
            send_char(CH_DOT, 1'b1);
            send_char(8'($urandom_range(0, 255)), 1'b1);
        end
        else if (pick < 86)
        begin
            // line comment, ended by newline or end of buffer
            send_char(CH_PERCENT, 1'b1);
            repeat (span)
            begin
                do
                    c = 8'($urandom_range(1, 255));
                while (c == CH_LF);
                send_char(c, 1'b1);
            end
            if ($urandom_range(0, 3) == 0)
                send_char(CH_NUL, 1'b1);
            else
                send_char(CH_LF, 1'b1);
        end
        else if (pick < 88)
            send_char(CH_NUL, 1'b1);
        else
            send_char(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed clause: every bracket and bar, var, int, comma, cut,
        // semicolon, graphic run, quoted atom,
        // dot turning into a graphic atom, then blank ends the word
        send_text("f(X,[1|_]):-!;'a'.x ");
        // unknown code at the top of the range
        send_char(8'hFF, 1'b1);
        // comment up to newline, then dot closed by end of buffer
        send_text("%q\n.");
        send_char(CH_NUL, 1'b1);
        // quote left open at end of buffer
        send_text("'b");
        send_char(CH_NUL, 1'b1);

        // let the token queue run dry once
        hold_off();

        while (chars_sent < CHAR_GOAL)
        begin
            calm <= (chars_sent >= 450 && chars_sent < 650);
            send_piece();
        end

        hold_off();
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_count == 0 && tokens_pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
